@@ hw/rtl/wbss_pkg.sv @@
// Shared types, register codes and pattern helpers for the byte signature scanner.
`default_nettype none

package wbss_pkg;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned RVA_W     = 32;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PLEN_W    = 5;
  localparam int unsigned CARE_W    = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_BASE_RVA       = 3'd4
  } cfg_reg_t;

  // Control view of the item held in the window stage
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [POS_W-1:0] pos;
  } stage_ctl_t;

  // Pattern byte j; bytes from sixteen on read as zero
  function automatic logic [7:0] pat_byte(input logic [CFG_W-1:0] low,
                                          input logic [CFG_W-1:0] high,
                                          input int unsigned j);
    logic [7:0] b;
    b = 8'h00;
    if (j < 8) begin
      b = low[8*j +: 8];
    end else if (j < 16) begin
      b = high[8*(j-8) +: 8];
    end
    return b;
  endfunction

  // Care bit j; bytes from sixteen on are wildcards
  function automatic logic pat_care(input logic [CARE_W-1:0] mask,
                                    input int unsigned j);
    logic c;
    c = 1'b0;
    if (j < CARE_W) begin
      c = mask[j];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wbss_if.sv @@
// Valid/ready channel interfaces for input bytes and match results.
`default_nettype none

interface wbss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbss_out_if;
  logic                         valid;
  logic                         ready;
  logic [wbss_pkg::RVA_W-1:0]   match_rva;

  modport source (output valid, output match_rva, input ready);
  modport sink (input valid, input match_rva, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/wbss_window.sv @@
// Input stage: byte window, fill count and range position of the held item.
`default_nettype none

module wbss_window #(
  parameter int unsigned MAX_PATTERN_LEN = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  input  wire logic                 advance,
  output logic                      in_ready,
  output logic [7:0]                window [MAX_PATTERN_LEN],
  output logic [$clog2(MAX_PATTERN_LEN+1)-1:0] fill,
  output wbss_pkg::stage_ctl_t      stage
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN_LEN + 1);

  logic             accept;
  logic [LEN_W-1:0] fill_base;
  logic [LEN_W-1:0] fill_next;

  // Stage takes a new byte when empty or when its item moves on
  assign in_ready = !stage.valid || advance;
  assign accept   = in_valid && in_ready;

  // Fill count includes the newest byte; restarts after the end of a range
  assign fill_base = stage.last ? '0 : fill;
  assign fill_next = (fill_base < LEN_W'(MAX_PATTERN_LEN)) ? fill_base + 1'b1 : fill_base;

  // Control state and position of the held byte within its range
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
      stage.last  <= 1'b1;
      fill        <= '0;
    end else if (accept) begin
      stage.valid <= 1'b1;
      stage.last  <= last_byte;
      stage.pos   <= stage.last ? '0 : stage.pos + 1'b1;
      fill        <= fill_next;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
  end

  // Window, newest byte first; cleared behind the first byte of a range
  always_ff @(posedge clk) begin
    if (accept) begin
      window[0] <= data_byte;
      for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
        window[k] <= stage.last ? 8'h00 : window[k-1];
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wbss_match.sv @@
// Masked compare of the window against the pattern and the result register.
`default_nettype none

module wbss_match #(
  parameter int unsigned MAX_PATTERN_LEN = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [7:0]                         window [MAX_PATTERN_LEN],
  input  wire logic [$clog2(MAX_PATTERN_LEN+1)-1:0] fill,
  input  wire wbss_pkg::stage_ctl_t               stage,
  input  wire logic [wbss_pkg::CFG_W-1:0]         pattern_low,
  input  wire logic [wbss_pkg::CFG_W-1:0]         pattern_high,
  input  wire logic [wbss_pkg::CARE_W-1:0]        care_mask,
  input  wire logic [wbss_pkg::PLEN_W-1:0]        pattern_length,
  input  wire logic [wbss_pkg::RVA_W-1:0]         base_rva,
  input  wire logic                               out_ready,
  output logic                                    advance,
  output logic                                    out_valid,
  output logic [wbss_pkg::RVA_W-1:0]              match_rva
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam int unsigned IDX_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] age;
  logic             hit;

  // Lengths beyond the window act as the full window
  assign len_eff = (32'(pattern_length) > 32'(MAX_PATTERN_LEN)) ?
                   LEN_W'(MAX_PATTERN_LEN) : LEN_W'(pattern_length);

  // Pattern byte j lines up with the byte of age len-1-j
  always_comb begin
    hit = (len_eff != '0) && (fill >= len_eff);
    age = '0;
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      age = LEN_W'(len_eff - LEN_W'(j) - LEN_W'(1));
      if ((LEN_W'(j) < len_eff) && wbss_pkg::pat_care(care_mask, j) &&
          (window[age[IDX_W-1:0]] != wbss_pkg::pat_byte(pattern_low, pattern_high, j))) begin
        hit = 1'b0;
      end
    end
  end

  // Held item moves on when the result register is free or being drained
  assign advance = stage.valid && (!out_valid || out_ready);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Match start address: base plus offset of the first matched byte
  always_ff @(posedge clk) begin
    if (advance && hit) begin
      match_rva <= base_rva + stage.pos - wbss_pkg::RVA_W'(len_eff) + 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wildcard_byte_signature_scanner_top.sv @@
// Path: an accepted byte is held in the window stage, then its match result is registered in the result register.
// Throughput: one byte per cycle; the window stage and result register both refill
// in the cycle they empty, so a stalled result only holds the scanner once both are full.
// Reset: rst is synchronous; registers return to their defaults (pattern length one),
// the window restarts as a new range and no result is pending.
// Top level: configuration registers, window stage and matcher.
`default_nettype none

module wildcard_byte_signature_scanner_top #(
  parameter int unsigned MAX_PATTERN_LEN = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [wbss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wbss_pkg::CFG_W-1:0]        cfg_wdata,
  wbss_in_if.sink                                byte_in,
  wbss_out_if.source                             match_out
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN_LEN + 1);

  logic [wbss_pkg::CFG_W-1:0]   pattern_low;
  logic [wbss_pkg::CFG_W-1:0]   pattern_high;
  logic [wbss_pkg::CARE_W-1:0]  care_mask;
  logic [wbss_pkg::PLEN_W-1:0]  pattern_length;
  logic [wbss_pkg::RVA_W-1:0]   base_rva;

  logic [7:0]                   window [MAX_PATTERN_LEN];
  logic [LEN_W-1:0]             fill;
  wbss_pkg::stage_ctl_t         stage;
  logic                         advance;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '0;
      pattern_length <= wbss_pkg::PLEN_W'(1);
      base_rva       <= '0;
    end else if (cfg_we) begin
      unique case (wbss_pkg::cfg_reg_t'(cfg_index))
        wbss_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_wdata;
        wbss_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_wdata;
        wbss_pkg::REG_CARE_MASK:      care_mask      <= cfg_wdata[wbss_pkg::CARE_W-1:0];
        wbss_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_wdata[wbss_pkg::PLEN_W-1:0];
        wbss_pkg::REG_BASE_RVA:       base_rva       <= cfg_wdata[wbss_pkg::RVA_W-1:0];
        default: ;
      endcase
    end
  end

  // Window stage
  wbss_window #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .data_byte(byte_in.data_byte),
    .last_byte(byte_in.last_byte),
    .advance  (advance),
    .in_ready (byte_in.ready),
    .window   (window),
    .fill     (fill),
    .stage    (stage)
  );

  // Compare and result register
  wbss_match #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_match (
    .clk           (clk),
    .rst           (rst),
    .window        (window),
    .fill          (fill),
    .stage         (stage),
    .pattern_low   (pattern_low),
    .pattern_high  (pattern_high),
    .care_mask     (care_mask),
    .pattern_length(pattern_length),
    .base_rva      (base_rva),
    .out_ready     (match_out.ready),
    .advance       (advance),
    .out_valid     (match_out.valid),
    .match_rva     (match_out.match_rva)
  );

endmodule

`default_nettype wire

@@ tb/tb_wildcard_byte_signature_scanner_top.sv @@
// Self-checking testbench for the wildcard byte signature scanner: directed and random ranges.
`timescale 1ns / 100ps

module tb_wildcard_byte_signature_scanner_top;

  localparam int unsigned MAX_LEN     = 16;
  localparam int          DRAIN_WAIT  = 4;
  localparam int          STALL_LIMIT = 20000;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  wbss_pkg::cfg_reg_t             cfg_index;
  logic [wbss_pkg::CFG_W-1:0]     cfg_wdata;

  wbss_in_if  byte_if ();
  wbss_out_if match_if ();

  wildcard_byte_signature_scanner_top #(
    .MAX_PATTERN_LEN(MAX_LEN)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .byte_in   (byte_if),
    .match_out (match_if)
  );

  // Scanner copy: registers as last written
  logic [63:0]      pat_lo   = '0;
  logic [63:0]      pat_hi   = '0;
  logic [15:0]      care     = '0;
  logic [4:0]       pat_len  = 5'd1;
  logic [31:0]      base_rva = '0;

  // Scanner copy: range state
  logic [7:0]       win_bytes [MAX_LEN-1];
  logic [31:0]      byte_pos  = '0;
  logic [4:0]       fill_cnt  = '0;

  logic [31:0]      match_rva_q [$];
  int               errors      = 0;
  int               sent_count  = 0;
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  int               stall_cnt   = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [7:0] pattern_byte(input int unsigned j);
    logic [7:0] b;
    if (j < 8) begin
      b = pat_lo[8*j +: 8];
    end else begin
      b = pat_hi[8*(j-8) +: 8];
    end
    return b;
  endfunction

  // Window compare for one byte; advances or clears the range state
  function automatic bit scan_byte(input logic [7:0] cur, input logic lst,
                                   output logic [31:0] rva);
    int unsigned len;
    int unsigned j;
    int unsigned age;
    logic [7:0]  b;
    bit          hit;
    hit = 1'b0;
    rva = '0;
    len = (pat_len > MAX_LEN) ? MAX_LEN : pat_len;
    if (len != 0 && fill_cnt + 1 >= len) begin
      hit = 1'b1;
      for (j = 0; j < len; j++) begin
        age = len - 1 - j;
        b   = (age == 0) ? cur : win_bytes[age-1];
        if (care[j] && b != pattern_byte(j)) hit = 1'b0;
      end
      if (hit) rva = base_rva + byte_pos - (len - 1);
    end
    if (lst) begin
      for (j = 0; j < MAX_LEN - 1; j++) win_bytes[j] = '0;
      byte_pos = '0;
      fill_cnt = '0;
    end else begin
      for (j = MAX_LEN - 2; j > 0; j--) win_bytes[j] = win_bytes[j-1];
      win_bytes[0] = cur;
      if (fill_cnt < MAX_LEN - 1) fill_cnt++;
      byte_pos++;
    end
    return hit;
  endfunction

  // Receiver back-pressure
  always @(negedge clk) begin
    match_if.ready = ($urandom_range(99) >= rx_idle_pct);
  end

  // Prediction on each input transfer, check on each result transfer
  always @(posedge clk) begin
    logic [31:0] rva;
    logic [31:0] want;
    if (!rst) begin
      if (match_if.valid && match_if.ready) begin
        if (match_rva_q.size() == 0) begin
          $display("%0t: unexpected match_rva, expected none, actual %h",
                   $time, match_if.match_rva);
          errors++;
        end else begin
          want = match_rva_q.pop_front();
          if (match_if.match_rva !== want) begin
            $display("%0t: match_rva mismatch, expected %h, actual %h",
                     $time, want, match_if.match_rva);
            errors++;
          end
        end
      end
      if (byte_if.valid && byte_if.ready) begin
        if (scan_byte(byte_if.data_byte, byte_if.last_byte, rva)) begin
          match_rva_q = {match_rva_q, rva};
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((byte_if.valid && byte_if.ready) || (match_if.valid && match_if.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  // One byte transfer; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_if.valid = 1'b0;
      @(negedge clk);
    end
    byte_if.valid     = 1'b1;
    byte_if.data_byte = b;
    byte_if.last_byte = lst;
    do @(posedge clk); while (!byte_if.ready);
    @(negedge clk);
    byte_if.valid = 1'b0;
    sent_count++;
  endtask

  // Wait until every expected match has come and the pipeline is empty
  task automatic drain();
    while (match_rva_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic cfg_write(input wbss_pkg::cfg_reg_t r, input logic [63:0] v);
    cfg_we    = 1'b1;
    cfg_index = r;
    cfg_wdata = v;
    case (r)
      wbss_pkg::REG_PATTERN_LOW:    pat_lo   = v;
      wbss_pkg::REG_PATTERN_HIGH:   pat_hi   = v;
      wbss_pkg::REG_CARE_MASK:      care     = v[15:0];
      wbss_pkg::REG_PATTERN_LENGTH: pat_len  = v[4:0];
      wbss_pkg::REG_BASE_RVA:       base_rva = v[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic setup(input logic [63:0] lo, input logic [63:0] hi, input logic [15:0] cm,
                       input logic [4:0] len, input logic [31:0] base);
    drain();
    cfg_write(wbss_pkg::REG_PATTERN_LOW, lo);
    cfg_write(wbss_pkg::REG_PATTERN_HIGH, hi);
    cfg_write(wbss_pkg::REG_CARE_MASK, {48'd0, cm});
    cfg_write(wbss_pkg::REG_PATTERN_LENGTH, {59'd0, len});
    cfg_write(wbss_pkg::REG_BASE_RVA, {32'd0, base});
  endtask

  // Defaults after reset: one wildcard byte, so every byte matches
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Three-byte pattern with a wildcard in the middle, two hits in one range
  task automatic test_masked_match();
    setup(64'h0000_0000_005A_FF00, 64'd0, 16'h0005, 5'd3, 32'h0000_1000);
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // Zero length never matches
  task automatic test_zero_length();
    setup(64'd0, 64'd0, 16'h0000, 5'd0, 32'd0);
    send_byte(8'h00, 1'b1);
  endtask

  // Range shorter than an all-wildcard pattern gives nothing
  task automatic test_short_range();
    setup(64'd0, 64'd0, 16'h0000, 5'd3, 32'd0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // Address wraps past the top of the 32-bit space
  task automatic test_rva_wrap();
    setup({64{1'b1}}, {64{1'b1}}, 16'h0000, 5'd2, 32'hFFFF_FFFF);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  // Oversized length acts as sixteen; only the end bytes are cared for
  task automatic test_length_overflow();
    int i;
    setup(64'h0000_0000_0000_00FF, 64'd0, 16'h8001, 5'd31, 32'h0000_2000);
    send_byte(8'hFF, 1'b0);
    for (i = 0; i < 14; i++) send_byte(8'($urandom), 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Random register set, extremes weighted in
  task automatic random_setup();
    int          r;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] cm;
    logic [4:0]  len;
    logic [31:0] base;
    r = $urandom_range(99);
    if (r < 5)       len = 5'd0;
    else if (r < 15) len = 5'($urandom_range(17, 31));
    else if (r < 30) len = 5'($urandom_range(7, 16));
    else             len = 5'($urandom_range(1, 6));
    r = $urandom_range(9);
    if (r == 0)      cm = 16'h0000;
    else if (r == 1) cm = 16'hFFFF;
    else             cm = 16'($urandom);
    r = $urandom_range(9);
    if (r == 0)      begin lo = '0;          hi = '0;          end
    else if (r == 1) begin lo = {64{1'b1}};  hi = {64{1'b1}};  end
    else             begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
    r = $urandom_range(9);
    if (r < 2)       base = 32'hFFFF_FFFF - $urandom_range(0, 20);
    else if (r == 2) base = 32'd0;
    else             base = $urandom;
    setup(lo, hi, cm, len, base);
  endtask

  // One range: random filler with planted copies of the pattern, some broken
  task automatic send_range();
    int          n;
    int          i;
    int          k;
    int          len;
    int          flip;
    bit          open_end;
    logic [7:0]  b;
    n        = ($urandom_range(19) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
    len      = (pat_len > MAX_LEN) ? MAX_LEN : pat_len;
    open_end = ($urandom_range(9) == 0);
    i = 0;
    while (i < n) begin
      if (len > 0 && i + len <= n && $urandom_range(2) == 0) begin
        flip = ($urandom_range(4) == 0) ? $urandom_range(len - 1) : -1;
        for (k = 0; k < len; k++) begin
          b = care[k] ? pattern_byte(k) : 8'($urandom);
          if (k == flip) b = b ^ (8'h01 << $urandom_range(7));
          i++;
          send_byte(b, i == n && !open_end);
        end
      end else begin
        b = ($urandom_range(1) == 0 && len > 0) ?
            pattern_byte($urandom_range(len - 1)) : 8'($urandom);
        i++;
        send_byte(b, i == n && !open_end);
      end
    end
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct, input int n_items);
    int target;
    int r;
    int ranges;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target = sent_count + n_items;
    while (sent_count < target) begin
      random_setup();
      ranges = $urandom_range(1, 6);
      for (r = 0; r < ranges; r++) send_range();
    end
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = wbss_pkg::REG_PATTERN_LOW;
    cfg_wdata         = '0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_byte = 1'b0;
    match_if.ready    = 1'b0;
    for (int i = 0; i < MAX_LEN - 1; i++) win_bytes[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    tx_idle_pct = 23;
    rx_idle_pct = 83;
    test_reset_defaults();
    test_masked_match();
    test_zero_length();
    test_short_range();
    test_rva_wrap();
    test_length_overflow();

    test_random(23, 83, 320);
    test_random(83, 23, 320);
    test_random(0, 0, 320);

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ wildcard_byte_signature_scanner_top.f @@
hw/rtl/wbss_pkg.sv
hw/rtl/wbss_if.sv
hw/rtl/wbss_window.sv
hw/rtl/wbss_match.sv
hw/rtl/wildcard_byte_signature_scanner_top.sv
tb/tb_wildcard_byte_signature_scanner_top.sv
